// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define CPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/cps_pkg.sv
// types and constants of the closest point on segment block
package cps_pkg;

    localparam int CoordW    = 32;
    localparam int QfbDefault = 24;
    // width of projection, squared length and remainder
    localparam int LenW      = 2 * CoordW + 4;

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_MID   = 2'd1,
        REG_END   = 2'd2
    } t_region;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic signed [CoordW-1:0] seg_start_x;
        logic signed [CoordW-1:0] seg_start_y;
        logic signed [CoordW-1:0] seg_start_z;
        logic signed [CoordW-1:0] seg_end_x;
        logic signed [CoordW-1:0] seg_end_y;
        logic signed [CoordW-1:0] seg_end_z;
    } t_cps_in;

    typedef struct packed {
        logic signed [CoordW-1:0] closest_x;
        logic signed [CoordW-1:0] closest_y;
        logic signed [CoordW-1:0] closest_z;
        logic [1:0]               region;
    } t_cps_out;

    typedef struct packed {
        logic [2:0][CoordW-1:0] s;
        logic [2:0][CoordW:0]   d;
        t_region                region;
    } t_geo;

endpackage

// File: hw/rtl/cps_front.sv
// edge vector, products and sums for projection and squared length
module cps_front import cps_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_cps_in                i_data,
    output logic                   o_valid,
    output t_geo                   o_geo,
    output logic signed [LenW-1:0] o_proj,
    output logic [LenW-1:0]        o_len2
);

    localparam int PW = 2 * CoordW + 2;

    logic [2:0][CoordW-1:0] w_p, w_s, w_e;

    logic                          r_a_v, r_b_v, r_c_v;
    logic [2:0][CoordW-1:0]        r_a_s, r_b_s, r_c_s;
    logic signed [CoordW:0]        r_a_d  [3];
    logic signed [CoordW:0]        r_a_ps [3];
    logic [2:0][CoordW:0]          r_b_d, r_c_d;
    logic signed [PW-1:0]          r_b_pd [3];
    logic signed [PW-1:0]          r_b_dd [3];
    logic signed [LenW-1:0]        r_c_proj;
    logic [LenW-1:0]               r_c_len2;
    logic signed [LenW-1:0]        n_proj, n_len2;

    assign w_p = {i_data.point_x, i_data.point_y, i_data.point_z};
    assign w_s = {i_data.seg_start_x, i_data.seg_start_y, i_data.seg_start_z};
    assign w_e = {i_data.seg_end_x, i_data.seg_end_y, i_data.seg_end_z};

    always_comb begin
        n_proj = '0;
        n_len2 = '0;
        for (int i = 0; i < 3; i++) begin
            n_proj = n_proj + LenW'(r_b_pd[i]);
            n_len2 = n_len2 + LenW'(r_b_dd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_s <= w_s;
            for (int i = 0; i < 3; i++) begin
                r_a_d[i]  <= $signed({w_e[i][CoordW-1], w_e[i]})
                           - $signed({w_s[i][CoordW-1], w_s[i]});
                r_a_ps[i] <= $signed({w_p[i][CoordW-1], w_p[i]})
                           - $signed({w_s[i][CoordW-1], w_s[i]});
                r_b_pd[i] <= r_a_ps[i] * r_a_d[i];
                r_b_dd[i] <= r_a_d[i] * r_a_d[i];
                r_b_d[i]  <= r_a_d[i];
            end
            r_b_s    <= r_a_s;
            r_c_s    <= r_b_s;
            r_c_d    <= r_b_d;
            r_c_proj <= n_proj;
            r_c_len2 <= n_len2;
        end
    end

    assign o_valid      = r_c_v;
    assign o_geo.s      = r_c_s;
    assign o_geo.d      = r_c_d;
    assign o_geo.region = REG_START;
    assign o_proj       = r_c_proj;
    assign o_len2       = r_c_len2;

endmodule

// File: hw/rtl/cps_div.sv
// region decision and restoring divider, one quotient bit per stage
module cps_div import cps_pkg::*; #(
    parameter int QFB = QfbDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_geo                   i_geo,
    input  logic signed [LenW-1:0] i_proj,
    input  logic [LenW-1:0]        i_len2,
    output logic                   o_valid,
    output t_geo                   o_geo,
    output logic [QFB-1:0]         o_q
);

    logic            r_r_v;
    t_geo            r_r_geo;
    logic [LenW-1:0] r_r_rem, r_r_len2;
    t_region         n_region;

    logic            r_k_v    [QFB];
    t_geo            r_k_geo  [QFB];
    logic [LenW-1:0] r_k_rem  [QFB];
    logic [LenW-1:0] r_k_len2 [QFB];
    logic [QFB-1:0]  r_k_q    [QFB];

    always_comb begin
        priority if (i_proj[LenW-1] || i_proj == '0) begin
            n_region = REG_START;
        end else if (LenW'(i_proj) >= i_len2) begin
            n_region = REG_END;
        end else begin
            n_region = REG_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (i_en) begin
            r_r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r_geo.s      <= i_geo.s;
            r_r_geo.d      <= i_geo.d;
            r_r_geo.region <= n_region;
            r_r_rem        <= LenW'(i_proj);
            r_r_len2       <= i_len2;
        end
    end

    for (genvar k = 0; k < QFB; k++) begin : g_step
        logic            w_v;
        t_geo            w_geo;
        logic [LenW-1:0] w_rem, w_len2, w_sh;
        logic [QFB-1:0]  w_q;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign w_v    = r_r_v;
            assign w_geo  = r_r_geo;
            assign w_rem  = r_r_rem;
            assign w_len2 = r_r_len2;
            assign w_q    = '0;
        end else begin : g_next
            assign w_v    = r_k_v[k-1];
            assign w_geo  = r_k_geo[k-1];
            assign w_rem  = r_k_rem[k-1];
            assign w_len2 = r_k_len2[k-1];
            assign w_q    = r_k_q[k-1];
        end

        assign w_sh = {w_rem[LenW-2:0], 1'b0};
        assign w_ge = (w_sh >= w_len2);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_v[k] <= 1'b0;
            end else if (i_en) begin
                r_k_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_k_geo[k]  <= w_geo;
                r_k_len2[k] <= w_len2;
                r_k_rem[k]  <= w_ge ? (w_sh - w_len2) : w_sh;
                r_k_q[k]    <= {w_q[QFB-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_k_v[QFB-1];
    assign o_geo   = r_k_geo[QFB-1];
    assign o_q     = r_k_q[QFB-1];

endmodule

// File: hw/rtl/cps_scale.sv
// scales the edge by the quotient and forms the output register
module cps_scale import cps_pkg::*; #(
    parameter int QFB = QfbDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_geo           i_geo,
    input  logic [QFB-1:0] i_q,
    output logic           o_valid,
    output t_cps_out       o_data
);

    localparam int MW = CoordW + 1 + QFB;

    logic                   r_m_v, r_o_v;
    t_geo                   r_m_geo;
    logic [MW-1:0]          r_m_prod [3];
    logic [CoordW:0]        w_mag    [3];
    logic [2:0][CoordW-1:0] n_res;
    logic [CoordW+1:0]      w_off    [3];
    logic [CoordW+1:0]      w_sum    [3];
    t_cps_out               r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_geo.d[i][CoordW] ? (CoordW+1)'(-i_geo.d[i]) : i_geo.d[i];
            w_off[i] = {1'b0, r_m_prod[i][QFB +: CoordW+1]};
            w_sum[i] = {{2{r_m_geo.s[i][CoordW-1]}}, r_m_geo.s[i]}
                     + (r_m_geo.d[i][CoordW] ? (CoordW+2)'(-w_off[i]) : w_off[i]);
            unique case (r_m_geo.region)
                REG_START: n_res[i] = r_m_geo.s[i];
                REG_END:   n_res[i] = r_m_geo.s[i] + r_m_geo.d[i][CoordW-1:0];
                REG_MID:   n_res[i] = w_sum[i][CoordW-1:0];
                default:   n_res[i] = r_m_geo.s[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_m_v <= i_valid;
            r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_geo <= i_geo;
            for (int i = 0; i < 3; i++) begin
                r_m_prod[i] <= MW'(w_mag[i]) * MW'(i_q);
            end
            r_out.closest_x <= n_res[2];
            r_out.closest_y <= n_res[1];
            r_out.closest_z <= n_res[0];
            r_out.region    <= r_m_geo.region;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_out;

endmodule

// File: hw/rtl/closest_point_on_segment.sv
// top level of the closest point on segment pipeline
// usage:
//   input channel: i_valid, i_data (query point, segment start and end, Q20.12),
//   o_stall back to the sender; an item is taken when i_valid is high and
//   o_stall low.
//   output channel: o_valid, o_data (closest point and region), i_stall from
//   the receiver; an item leaves when o_valid is high and i_stall low.
//   throughput: one item per cycle, every cycle, while the receiver takes items.
//   stages: three front stages (edge, products, sums), one region stage, one
//   divider stage per quotient bit and two scaling stages.
//   the whole pipeline moves as one; it holds while the output item is valid
//   and stalled, and then o_stall is high; empty slots hold with the rest.
//   reset clears every valid bit; no item is in flight afterwards.
//   region: 0 clamped to start, 1 interior, 2 clamped to end.
module closest_point_on_segment import cps_pkg::*; #(
    parameter int QUOTIENT_FRAC_BITS = QfbDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cps_in  i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_cps_out o_data,
    input  logic     i_stall
);

    logic                   w_en;
    logic                   w_f_v, w_d_v;
    t_geo                   w_f_geo, w_d_geo;
    logic signed [LenW-1:0] w_proj;
    logic [LenW-1:0]        w_len2;
    logic [QUOTIENT_FRAC_BITS-1:0] w_q;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    cps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_f_v),
        .o_geo   (w_f_geo),
        .o_proj  (w_proj),
        .o_len2  (w_len2)
    );

    cps_div #(.QFB(QUOTIENT_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_geo   (w_f_geo),
        .i_proj  (w_proj),
        .i_len2  (w_len2),
        .o_valid (w_d_v),
        .o_geo   (w_d_geo),
        .o_q     (w_q)
    );

    cps_scale #(.QFB(QUOTIENT_FRAC_BITS)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_v),
        .i_geo   (w_d_geo),
        .i_q     (w_q),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// File: hw/rtl/cps_check.sv
// port checker for the closest point on segment block
`include "assert_macros.svh"

module cps_check import cps_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input t_cps_in  i_data,
    input logic     o_stall,
    input logic     o_valid,
    input t_cps_out o_data,
    input logic     i_stall
);

    `CPS_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_data), "output item changed under stall")
    `CPS_ASSERT(a_stall_cause, o_stall |-> o_valid && i_stall, "input stalled without a stalled output item")
    `CPS_ASSERT(a_stall_free, o_valid && !i_stall |-> !o_stall, "input stalled while output drains")
    `CPS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "output item present after reset")

endmodule

bind closest_point_on_segment cps_check u_cps_check (.*);

// File: tb/closest_point_on_segment_tb.sv
// testbench for the closest point on segment block: directed and random queries
module closest_point_on_segment_tb import cps_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Qfb = QfbDefault;
    localparam int Latency = Qfb + 6;
    localparam longint CycleLimit = 400000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    t_cps_in  i_data;
    logic     o_stall;
    logic     o_valid;
    t_cps_out o_data;
    logic     i_stall;

    t_cps_out closest_due[$];
    int       error_count;
    longint   cycle_count;
    bit       long_stalls;
    // item taken at the last rising edge, recorded for back-to-back driving
    logic     last_taken;

    closest_point_on_segment #(.QUOTIENT_FRAC_BITS(Qfb)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_cps_out closest_point(t_cps_in q);
        t_cps_out r;
        logic signed [31:0] p[3], s[3], e[3];
        logic signed [32:0] d[3];
        logic signed [33:0] ps;
        logic signed [69:0] proj, len2;
        logic [69:0] rem;
        logic [Qfb-1:0] quo;
        logic [32:0] dmag;
        logic [32+Qfb:0] prod;
        logic signed [33:0] off;
        logic signed [33:0] res[3];
        p = '{q.point_x, q.point_y, q.point_z};
        s = '{q.seg_start_x, q.seg_start_y, q.seg_start_z};
        e = '{q.seg_end_x, q.seg_end_y, q.seg_end_z};
        proj = '0;
        len2 = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 33'(e[i]) - 33'(s[i]);
            ps = 34'(p[i]) - 34'(s[i]);
            proj = proj + 70'(ps) * 70'(d[i]);
            len2 = len2 + 70'(d[i]) * 70'(d[i]);
        end
        if (proj <= 0) begin
            r.region = REG_START;
            res = '{34'(s[0]), 34'(s[1]), 34'(s[2])};
        end else if (proj >= len2) begin
            r.region = REG_END;
            res = '{34'(e[0]), 34'(e[1]), 34'(e[2])};
        end else begin
            r.region = REG_MID;
            rem = proj;
            quo = '0;
            for (int b = 0; b < Qfb; b++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= len2) begin
                    rem = rem - len2;
                    quo[0] = 1'b1;
                end
            end
            for (int i = 0; i < 3; i++) begin
                dmag = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
                prod = (33 + Qfb)'(dmag) * (33 + Qfb)'(quo);
                off = 34'(prod >> Qfb);
                res[i] = 34'(s[i]) + (d[i] < 0 ? -off : off);
            end
        end
        r.closest_x = res[0][31:0];
        r.closest_y = res[1][31:0];
        r.closest_z = res[2][31:0];
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // drops valid with junk on the data for one cycle
    task automatic idle_input();
        i_valid <= 1'b0;
        i_data  <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
        @(negedge i_clk);
    endtask

    task automatic send_query(t_cps_in q);
        int g;
        g = gap_len();
        if (g != 0) begin
            idle_input();
            repeat (g - 1) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= q;
        do @(posedge i_clk); while (o_stall);
        closest_due.push_back(closest_point(q));
        @(negedge i_clk);
    endtask

    // near values keep products small and the interior region common
    function automatic logic [31:0] coord(int mode, logic [31:0] base);
        case (mode)
            0: return $urandom;
            1: return base + 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return base + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic t_cps_in random_query();
        t_cps_in q;
        int m;
        logic [31:0] b[3];
        m = $urandom_range(0, 9);
        m = (m < 3) ? 0 : (m < 6) ? 1 : (m < 9) ? 2 : 3;
        for (int i = 0; i < 3; i++) b[i] = $urandom;
        q.seg_start_x = coord(m, b[0]);
        q.seg_start_y = coord(m, b[1]);
        q.seg_start_z = coord(m, b[2]);
        q.seg_end_x   = coord(m, b[0]);
        q.seg_end_y   = coord(m, b[1]);
        q.seg_end_z   = coord(m, b[2]);
        q.point_x     = coord(m, b[0]);
        q.point_y     = coord(m, b[1]);
        q.point_z     = coord(m, b[2]);
        if ($urandom_range(0, 19) == 0) begin
            q.seg_end_x = q.seg_start_x;
            q.seg_end_y = q.seg_start_y;
            q.seg_end_z = q.seg_start_z;
        end
        return q;
    endfunction

    function automatic t_cps_in make_query(logic [31:0] px, py, pz, sx, sy, sz,
                                           ex, ey, ez);
        return {px, py, pz, sx, sy, sz, ex, ey, ez};
    endfunction

    task automatic test_directed();
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        // point before start, interior, past end, on the ends
        send_query(make_query(-32'sd4096, 0, 0, 0, 0, 0, 32'd40960, 0, 0));
        send_query(make_query(32'd12288, 32'd999, 0, 0, 0, 0, 32'd40960, 0, 0));
        send_query(make_query(32'd90000, 0, 0, 0, 0, 0, 32'd40960, 0, 0));
        send_query(make_query(0, 0, 0, 0, 0, 0, 32'd40960, 0, 0));
        send_query(make_query(32'd40960, 0, 0, 0, 0, 0, 32'd40960, 0, 0));
        // zero-length edge
        send_query(make_query(32'd5, 32'd6, 32'd7, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3));
        send_query(make_query(mx, mx, mx, mn, mn, mn, mn, mn, mn));
        // extreme coordinates
        send_query(make_query(mx, mx, mx, mn, mn, mn, mx, mx, mx));
        send_query(make_query(mn, mn, mn, mx, mx, mx, mn, mn, mn));
        send_query(make_query(0, 0, 0, mn, mn, mn, mx, mx, mx));
        send_query(make_query(mn, mx, 0, mx, mn, mx, mn, mx, mn));
        send_query(make_query(32'd1, 0, 0, mx, mx, mx, mn, mn, mn));
        send_query(make_query(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              0, 0, 0, 32'd3, 32'hffff_fffd, 32'd1));
        // negative edge components in the interior
        send_query(make_query(-32'sd7000, 32'd100, -32'sd3, 32'd1000, 32'd2000,
                              32'd3000, -32'sd90000, -32'sd5000, -32'sd7000));
        send_query(make_query(32'h0aaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0, 32'h1234_5678,
                              32'h9abc_def0, 32'h0f0f_0f0f, 32'hedcb_a987, 32'h6543_2100,
                              32'hf0f0_f0f0));
        idle_input();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_query(random_query());
        idle_input();
    endtask

    task automatic test_drain_pause();
        while (closest_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_back_to_back(int n);
        long_stalls = 1'b0;
        for (int i = 0; i < n; i++) begin
            i_valid <= 1'b1;
            i_data  <= random_query();
            @(negedge i_clk);
            while (!last_taken) @(negedge i_clk);
        end
        idle_input();
        long_stalls = 1'b1;
    endtask

    always @(posedge i_clk) begin
        last_taken <= i_rst_n && i_valid && !o_stall;
    end
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall && !long_stalls) begin
            closest_due.push_back(closest_point(i_data));
        end
    end

    always @(negedge i_clk) begin
        int k;
        k = $urandom_range(0, 99);
        if (!long_stalls) i_stall <= 1'b0;
        else if (i_stall) i_stall <= ($urandom_range(0, 9) < 8);
        else i_stall <= (k < 25);
    end

    always @(posedge i_clk) begin
        t_cps_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (closest_due.size() == 0) begin
                $display("%0t: unexpected item %h", $realtime, o_data);
                error_count++;
            end else begin
                want = closest_due.pop_front();
                if (o_data.closest_x !== want.closest_x
                    || o_data.closest_y !== want.closest_y
                    || o_data.closest_z !== want.closest_z
                    || o_data.region !== want.region) begin
                    $display("%0t: expected %h %h %h %0d, actual %h %h %h %0d", $realtime,
                             want.closest_x, want.closest_y, want.closest_z, want.region,
                             o_data.closest_x, o_data.closest_y, o_data.closest_z,
                             o_data.region);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("[closest_point_on_segment] ERROR");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        long_stalls = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(900);
        test_drain_pause();
        test_back_to_back(200);
        test_random(800);
        while (closest_due.size() != 0) @(negedge i_clk);
        repeat (Latency + 10) @(negedge i_clk);
        if (error_count == 0) $display("[closest_point_on_segment] OK");
        else $display("[closest_point_on_segment] ERROR");
        $finish;
    end

endmodule
